// ----- rtl/aavr_pkg.sv -----
package aavr_pkg;

    localparam int TURN_LSB     = 23040;
    localparam int QUARTER_LSB  = 5760;
    localparam int HORNER_STEPS = 6;
    localparam int RECIP_SHIFT  = 34;
    localparam int OUT_FRAC     = 16;

    localparam logic [18:0] RAD_PER_LSB_Q30 = 19'd292818;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

    localparam logic [7:0] SIN_K [HORNER_STEPS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [7:0] COS_K [HORNER_STEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12
    };
    localparam logic [31:0] SIN_M [HORNER_STEPS] = '{
        32'((64'd1 << RECIP_SHIFT) / 64'd156), 32'((64'd1 << RECIP_SHIFT) / 64'd110),
        32'((64'd1 << RECIP_SHIFT) / 64'd72),  32'((64'd1 << RECIP_SHIFT) / 64'd42),
        32'((64'd1 << RECIP_SHIFT) / 64'd20),  32'((64'd1 << RECIP_SHIFT) / 64'd6)
    };
    localparam logic [31:0] COS_M [HORNER_STEPS] = '{
        32'((64'd1 << RECIP_SHIFT) / 64'd182), 32'((64'd1 << RECIP_SHIFT) / 64'd132),
        32'((64'd1 << RECIP_SHIFT) / 64'd90),  32'((64'd1 << RECIP_SHIFT) / 64'd56),
        32'((64'd1 << RECIP_SHIFT) / 64'd30),  32'((64'd1 << RECIP_SHIFT) / 64'd12)
    };

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

endpackage

// ----- rtl/aavr_in_if.sv -----
interface aavr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [15:0] angle_deg;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                    output ready);
endinterface

// ----- rtl/aavr_out_if.sv -----
interface aavr_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] out_x;
    logic signed [17:0] out_y;
    logic signed [17:0] out_z;
    logic               degenerate;

    modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
    modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// ----- rtl/aavr_prescale.sv -----
module aavr_prescale #(
    parameter int IW = 32,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [IW-1:0] i_d [3],
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [31:0]   o_d [3],
    output logic                 o_zero,
    output logic [SW-1:0]        o_side
);
    localparam int PW = $clog2(IW);

    logic [IW-1:0] r1_mag [3];
    logic [2:0]    r1_neg;
    logic [IW-1:0] r1_or;
    logic [SW-1:0] r1_side;
    logic          r1_valid;

    logic [IW-1:0] r2_mag [3];
    logic [2:0]    r2_neg;
    logic          r2_zero;
    logic          r2_left;
    logic [PW-1:0] r2_sh;
    logic [SW-1:0] r2_side;
    logic          r2_valid;

    logic [30:0]   r3_mag [3];
    logic [2:0]    r3_neg;
    logic          r3_zero;
    logic [SW-1:0] r3_side;
    logic          r3_valid;

    logic [IW-1:0] n1_mag [3];
    logic [IW-1:0] n1_or;
    logic [PW-1:0] n2_pos;
    logic [30:0]   n3_mag [3];
    logic [IW-1:0] sh_tmp [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_d[i][IW-1] ? IW'(-i_d[i]) : IW'(i_d[i]);
        end
        n1_or = n1_mag[0] | n1_mag[1] | n1_mag[2];
    end

    always_comb begin
        n2_pos = '0;
        for (int i = 0; i < IW; i++) begin
            if (r1_or[i]) n2_pos = PW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh_tmp[i] = r2_left ? (r2_mag[i] << r2_sh) : (r2_mag[i] >> r2_sh);
            n3_mag[i] = sh_tmp[i][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_or   <= n1_or;
            r1_side <= i_side;
            for (int i = 0; i < 3; i++) r1_neg[i] <= i_d[i][IW-1];
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_or == '0);
            r2_left <= (n2_pos < PW'(30));
            r2_sh   <= (n2_pos < PW'(30)) ? PW'(30) - n2_pos : n2_pos - PW'(30);
            r2_side <= r1_side;
            r3_mag  <= n3_mag;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_side <= r2_side;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_d[i] = r3_neg[i] ? -$signed({1'b0, r3_mag[i]}) : $signed({1'b0, r3_mag[i]});
        end
    end

    assign o_valid = r3_valid;
    assign o_zero  = r3_zero;
    assign o_side  = r3_side;
endmodule

// ----- rtl/aavr_trig.sv -----
module aavr_trig #(
    parameter int FRAC = 16,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [15:0]     i_angle,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [FRAC+1:0] o_cos,
    output logic signed [FRAC+1:0] o_sin,
    output logic [SW-1:0]          o_side
);
    import aavr_pkg::*;

    localparam int NS = HORNER_STEPS;
    localparam int RS = 30 - FRAC;

    typedef struct packed {
        logic [30:0]   x;
        logic [31:0]   x2;
        t_quad         quad;
        logic [SW-1:0] side;
    } t_carry;

    // angle wrap and quadrant split
    logic          r0_valid;
    t_quad         r0_quad;
    logic [12:0]   r0_rem;
    logic [SW-1:0] r0_side;
    logic signed [16:0] n0_a;
    logic [14:0]   n0_r;
    t_quad         n0_quad;
    logic [14:0]   n0_rem;

    always_comb begin
        n0_a = 17'(i_angle);
        if (n0_a < 0) n0_a = n0_a + 17'sd23040;
        if (n0_a < 0) n0_a = n0_a + 17'sd23040;
        if (n0_a >= 17'sd23040) n0_a = n0_a - 17'sd23040;
        n0_r = n0_a[14:0];
        priority if (n0_r >= 15'(3 * QUARTER_LSB)) begin
            n0_quad = QUAD_3;
            n0_rem  = n0_r - 15'(3 * QUARTER_LSB);
        end else if (n0_r >= 15'(2 * QUARTER_LSB)) begin
            n0_quad = QUAD_2;
            n0_rem  = n0_r - 15'(2 * QUARTER_LSB);
        end else if (n0_r >= 15'(QUARTER_LSB)) begin
            n0_quad = QUAD_1;
            n0_rem  = n0_r - 15'(QUARTER_LSB);
        end else begin
            n0_quad = QUAD_0;
            n0_rem  = n0_r;
        end
    end

    logic          r1_valid;
    t_quad         r1_quad;
    logic [30:0]   r1_x;
    logic [SW-1:0] r1_side;
    logic [31:0]   n1_x;

    assign n1_x = 32'(r0_rem) * 32'(RAD_PER_LSB_Q30);

    logic          r2_valid;
    t_carry        r2_c;
    logic [61:0]   n2_sq;

    assign n2_sq = (62'(r1_x) * 62'(r1_x)) + (62'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_quad      <= n0_quad;
            r0_rem       <= n0_rem[12:0];
            r0_side      <= i_side;
            r1_quad      <= r0_quad;
            r1_x         <= n1_x[30:0];
            r1_side      <= r0_side;
            r2_c.x       <= r1_x;
            r2_c.x2      <= n2_sq[61:30];
            r2_c.quad    <= r1_quad;
            r2_c.side    <= r1_side;
        end
    end

    // Horner steps, three stages each: product, reciprocal, correction
    logic        ra_valid [NS];
    t_carry      ra_c     [NS];
    logic [62:0] ra_ps    [NS];
    logic [62:0] ra_pc    [NS];
    logic        rb_valid [NS];
    t_carry      rb_c     [NS];
    logic [31:0] rb_ps    [NS];
    logic [31:0] rb_pc    [NS];
    logic [63:0] rb_ms    [NS];
    logic [63:0] rb_mc    [NS];
    logic        rc_valid [NS];
    t_carry      rc_c     [NS];
    logic [30:0] rc_ts    [NS];
    logic [30:0] rc_tc    [NS];

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic        a_valid;
        t_carry      a_c;
        logic [30:0] a_ts;
        logic [30:0] a_tc;
        logic [29:0] qs0;
        logic [29:0] qc0;
        logic [32:0] rems;
        logic [32:0] remc;
        logic [29:0] qs;
        logic [29:0] qc;

        if (i == 0) begin : g_first
            assign a_valid = r2_valid;
            assign a_c     = r2_c;
            assign a_ts    = ONE_Q30;
            assign a_tc    = ONE_Q30;
        end else begin : g_next
            assign a_valid = rc_valid[i-1];
            assign a_c     = rc_c[i-1];
            assign a_ts    = rc_ts[i-1];
            assign a_tc    = rc_tc[i-1];
        end

        always_comb begin
            qs0  = rb_ms[i][63:RECIP_SHIFT];
            qc0  = rb_mc[i][63:RECIP_SHIFT];
            rems = 33'(rb_ps[i]) - 33'(qs0) * 33'(SIN_K[i]);
            remc = 33'(rb_pc[i]) - 33'(qc0) * 33'(COS_K[i]);
            qs   = qs0 + 30'(rems >= 33'(SIN_K[i]));
            qc   = qc0 + 30'(remc >= 33'(COS_K[i]));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ra_valid[i] <= 1'b0;
                rb_valid[i] <= 1'b0;
                rc_valid[i] <= 1'b0;
            end else if (i_en) begin
                ra_valid[i] <= a_valid;
                rb_valid[i] <= ra_valid[i];
                rc_valid[i] <= rb_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                ra_c[i]  <= a_c;
                ra_ps[i] <= 63'(a_c.x2) * 63'(a_ts);
                ra_pc[i] <= 63'(a_c.x2) * 63'(a_tc);
                rb_c[i]  <= ra_c[i];
                rb_ps[i] <= ra_ps[i][61:30];
                rb_pc[i] <= ra_pc[i][61:30];
                rb_ms[i] <= 64'(ra_ps[i][61:30]) * 64'(SIN_M[i]);
                rb_mc[i] <= 64'(ra_pc[i][61:30]) * 64'(COS_M[i]);
                rc_c[i]  <= rb_c[i];
                rc_ts[i] <= ONE_Q30 - 31'(qs);
                rc_tc[i] <= ONE_Q30 - 31'(qc);
            end
        end
    end

    // final products, cos clamp, rounding and quadrant map
    logic          rf1_valid;
    t_quad         rf1_quad;
    logic [SW-1:0] rf1_side;
    logic [61:0]   rf1_ps;
    logic [62:0]   rf1_pc;
    logic          rf2_valid;
    t_quad         rf2_quad;
    logic [SW-1:0] rf2_side;
    logic [30:0]   rf2_s;
    logic [30:0]   rf2_c;
    logic          rf3_valid;
    logic [SW-1:0] rf3_side;
    logic signed [FRAC+1:0] rf3_cos;
    logic signed [FRAC+1:0] rf3_sin;

    logic [31:0]   n_pc;
    logic [31:0]   n_cr;
    logic [31:0]   n_sr;
    logic signed [FRAC+1:0] n_cf;
    logic signed [FRAC+1:0] n_sf;
    logic signed [FRAC+1:0] n_cos;
    logic signed [FRAC+1:0] n_sin;

    assign n_pc = rf1_pc[62:31];

    always_comb begin
        n_cr = (32'(rf2_c) + (32'd1 << (RS - 1))) >> RS;
        n_sr = (32'(rf2_s) + (32'd1 << (RS - 1))) >> RS;
        n_cf = $signed({1'b0, n_cr[FRAC:0]});
        n_sf = $signed({1'b0, n_sr[FRAC:0]});
        unique case (rf2_quad)
            QUAD_0: begin n_cos = n_cf;  n_sin = n_sf;  end
            QUAD_1: begin n_cos = -n_sf; n_sin = n_cf;  end
            QUAD_2: begin n_cos = -n_cf; n_sin = -n_sf; end
            QUAD_3: begin n_cos = n_sf;  n_sin = -n_cf; end
            default: begin n_cos = n_cf; n_sin = n_sf;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_valid <= 1'b0;
            rf2_valid <= 1'b0;
            rf3_valid <= 1'b0;
        end else if (i_en) begin
            rf1_valid <= rc_valid[NS-1];
            rf2_valid <= rf1_valid;
            rf3_valid <= rf2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rf1_quad <= rc_c[NS-1].quad;
            rf1_side <= rc_c[NS-1].side;
            rf1_ps   <= 62'(rc_c[NS-1].x) * 62'(rc_ts[NS-1]);
            rf1_pc   <= 63'(rc_c[NS-1].x2) * 63'(rc_tc[NS-1]);
            rf2_quad <= rf1_quad;
            rf2_side <= rf1_side;
            rf2_s    <= rf1_ps[60:30];
            rf2_c    <= (n_pc >= 32'(ONE_Q30)) ? '0 : ONE_Q30 - n_pc[30:0];
            rf3_side <= rf2_side;
            rf3_cos  <= n_cos;
            rf3_sin  <= n_sin;
        end
    end

    assign o_valid = rf3_valid;
    assign o_cos   = rf3_cos;
    assign o_sin   = rf3_sin;
    assign o_side  = rf3_side;
endmodule

// ----- rtl/aavr_unit.sv -----
module aavr_unit #(
    parameter int IW   = 32,
    parameter int FRAC = 16,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [IW-1:0]   i_d [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [FRAC+1:0] o_u [3],
    output logic                   o_zero,
    output logic [SW-1:0]          o_side
);
    localparam int QW = FRAC + 2;
    localparam int CW = FRAC + 34;
    localparam int RT = 32;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
        logic [SW-1:0]    side;
    } t_carry;

    logic               p_valid;
    logic signed [31:0] p_d [3];
    logic               p_zero;
    logic [SW-1:0]      p_side;

    aavr_prescale #(.IW(IW), .SW(SW)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_d     (i_d),
        .i_side  (i_side),
        .o_valid (p_valid),
        .o_d     (p_d),
        .o_zero  (p_zero),
        .o_side  (p_side)
    );

    t_carry      n_sq_c;
    logic        r_sq_valid;
    t_carry      r_sq_c;
    logic [61:0] r_sq [3];
    logic        r_sum_valid;
    t_carry      r_sum_c;
    logic [63:0] r_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq_c.neg[i] = p_d[i][31];
            n_sq_c.mag[i] = p_d[i][31] ? 31'(-p_d[i]) : p_d[i][30:0];
        end
        n_sq_c.zero = p_zero;
        n_sq_c.side = p_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
        end else if (i_en) begin
            r_sq_valid  <= p_valid;
            r_sum_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_c  <= n_sq_c;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 62'(n_sq_c.mag[i]) * 62'(n_sq_c.mag[i]);
            end
            r_sum_c <= r_sq_c;
            r_sum   <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        end
    end

    // integer square root, one result bit per stage
    logic        r_rt_valid [RT];
    t_carry      r_rt_c     [RT];
    logic [63:0] r_rt_n     [RT];
    logic [63:0] r_rt_res   [RT];

    for (genvar k = 0; k < RT; k++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic        a_valid;
        t_carry      a_c;
        logic [63:0] a_n;
        logic [63:0] a_res;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign a_valid = r_sum_valid;
            assign a_c     = r_sum_c;
            assign a_n     = r_sum;
            assign a_res   = '0;
        end else begin : g_next
            assign a_valid = r_rt_valid[k-1];
            assign a_c     = r_rt_c[k-1];
            assign a_n     = r_rt_n[k-1];
            assign a_res   = r_rt_res[k-1];
        end

        assign trial = a_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_rt_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt_c[k] <= a_c;
                if (a_n >= trial) begin
                    r_rt_n[k]   <= a_n - trial;
                    r_rt_res[k] <= (a_res >> 1) + BIT;
                end else begin
                    r_rt_n[k]   <= a_n;
                    r_rt_res[k] <= a_res >> 1;
                end
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    logic          r_dv_valid [QW];
    t_carry        r_dv_c     [QW];
    logic [31:0]   r_dv_len   [QW];
    logic [CW-1:0] r_dv_rem   [QW][3];
    logic [QW-1:0] r_dv_q     [QW][3];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic          a_valid;
        t_carry        a_c;
        logic [31:0]   a_len;
        logic [CW-1:0] a_rem [3];
        logic [QW-1:0] a_q   [3];
        logic [CW-1:0] dvs;

        if (j == 0) begin : g_first
            assign a_valid = r_rt_valid[RT-1];
            assign a_c     = r_rt_c[RT-1];
            assign a_len   = r_rt_res[RT-1][31:0];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign a_rem[i] = (CW'(r_rt_c[RT-1].mag[i]) << FRAC)
                                + CW'(r_rt_res[RT-1][31:1]);
                assign a_q[i]   = '0;
            end
        end else begin : g_next
            assign a_valid = r_dv_valid[j-1];
            assign a_c     = r_dv_c[j-1];
            assign a_len   = r_dv_len[j-1];
            assign a_rem   = r_dv_rem[j-1];
            assign a_q     = r_dv_q[j-1];
        end

        assign dvs = CW'(a_len) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_valid[j] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_c[j]   <= a_c;
                r_dv_len[j] <= a_len;
                for (int i = 0; i < 3; i++) begin
                    if (a_rem[i] >= dvs) begin
                        r_dv_rem[j][i]  <= a_rem[i] - dvs;
                        r_dv_q[j][i]    <= a_q[i] | (QW'(1) << B);
                    end else begin
                        r_dv_rem[j][i]  <= a_rem[i];
                        r_dv_q[j][i]    <= a_q[i];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_u[i] = r_dv_c[QW-1].neg[i] ? -$signed(r_dv_q[QW-1][i])
                                         : $signed(r_dv_q[QW-1][i]);
        end
    end

    assign o_valid = r_dv_valid[QW-1];
    assign o_zero  = r_dv_c[QW-1].zero;
    assign o_side  = r_dv_c[QW-1].side;
endmodule

// ----- rtl/aavr_rod.sv -----
module aavr_rod #(
    parameter int FRAC = 16,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [FRAC+1:0] i_u [3],
    input  logic signed [31:0]     i_v [3],
    input  logic signed [FRAC+1:0] i_cos,
    input  logic signed [FRAC+1:0] i_sin,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [63:0]     o_r [3],
    output logic [SW-1:0]          o_side
);
    localparam int UW = FRAC + 2;
    localparam int PW = UW + 32;
    localparam int DW = PW + 2;
    localparam int RW = DW - FRAC;
    localparam int XW = UW + RW;
    localparam int WW = XW - FRAC;
    localparam int OW = WW + UW + 1;

    function automatic logic signed [RW-1:0] rsh_d(input logic signed [DW-1:0] x);
        logic [DW-1:0] m;
        m = x[DW-1] ? DW'(-x) : DW'(x);
        m = (m + (DW'(1) << (FRAC - 1))) >> FRAC;
        return x[DW-1] ? -$signed(m[RW-1:0]) : $signed(m[RW-1:0]);
    endfunction

    function automatic logic signed [WW-1:0] rsh_x(input logic signed [XW-1:0] x);
        logic [XW-1:0] m;
        m = x[XW-1] ? XW'(-x) : XW'(x);
        m = (m + (XW'(1) << (FRAC - 1))) >> FRAC;
        return x[XW-1] ? -$signed(m[WW-1:0]) : $signed(m[WW-1:0]);
    endfunction

    logic [5:0]    r_valid;
    logic [SW-1:0] r_side [6];

    logic signed [PW-1:0] r1_cp [6];
    logic signed [PW-1:0] r1_dp [3];
    logic signed [PW-1:0] r1_vc [3];
    logic signed [UW-1:0] r1_u  [3];
    logic signed [UW-1:0] r1_sin;
    logic signed [UW:0]   r1_omc;

    logic signed [RW-1:0] r2_cr [3];
    logic signed [RW-1:0] r2_dot;
    logic signed [PW-1:0] r2_vc [3];
    logic signed [UW-1:0] r2_u  [3];
    logic signed [UW-1:0] r2_sin;
    logic signed [UW:0]   r2_omc;

    logic signed [XW-1:0] r3_w  [3];
    logic signed [XW-1:0] r3_cs [3];
    logic signed [PW-1:0] r3_vc [3];
    logic signed [UW:0]   r3_omc;

    logic signed [WW-1:0] r4_w  [3];
    logic signed [XW-1:0] r4_cs [3];
    logic signed [PW-1:0] r4_vc [3];
    logic signed [UW:0]   r4_omc;

    logic signed [OW-1:0] r5_wo [3];
    logic signed [XW-1:0] r5_cs [3];
    logic signed [PW-1:0] r5_vc [3];

    logic signed [63:0]   r6_r  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < 6; s++) r_side[s] <= r_side[s-1];

            r1_cp[0] <= i_u[1] * i_v[2];
            r1_cp[1] <= i_u[2] * i_v[1];
            r1_cp[2] <= i_u[2] * i_v[0];
            r1_cp[3] <= i_u[0] * i_v[2];
            r1_cp[4] <= i_u[0] * i_v[1];
            r1_cp[5] <= i_u[1] * i_v[0];
            for (int i = 0; i < 3; i++) begin
                r1_dp[i] <= i_u[i] * i_v[i];
                r1_vc[i] <= i_v[i] * i_cos;
            end
            r1_u   <= i_u;
            r1_sin <= i_sin;
            r1_omc <= $signed((UW+1)'(1) << FRAC) - (UW+1)'(i_cos);

            for (int i = 0; i < 3; i++) begin
                r2_cr[i] <= rsh_d(DW'(r1_cp[2*i]) - DW'(r1_cp[2*i+1]));
            end
            r2_dot <= rsh_d(DW'(r1_dp[0]) + DW'(r1_dp[1]) + DW'(r1_dp[2]));
            r2_vc  <= r1_vc;
            r2_u   <= r1_u;
            r2_sin <= r1_sin;
            r2_omc <= r1_omc;

            for (int i = 0; i < 3; i++) begin
                r3_w[i]  <= r2_u[i] * r2_dot;
                r3_cs[i] <= r2_cr[i] * r2_sin;
            end
            r3_vc  <= r2_vc;
            r3_omc <= r2_omc;

            for (int i = 0; i < 3; i++) r4_w[i] <= rsh_x(r3_w[i]);
            r4_cs  <= r3_cs;
            r4_vc  <= r3_vc;
            r4_omc <= r3_omc;

            for (int i = 0; i < 3; i++) r5_wo[i] <= r4_w[i] * r4_omc;
            r5_cs <= r4_cs;
            r5_vc <= r4_vc;

            for (int i = 0; i < 3; i++) begin
                r6_r[i] <= 64'(r5_vc[i]) + 64'(r5_cs[i]) + 64'(r5_wo[i]);
            end
        end
    end

    assign o_valid = r_valid[5];
    assign o_r     = r6_r;
    assign o_side  = r_side[5];
endmodule

// ----- rtl/axis_angle_vector_rotate_top.sv -----
// Rotates a Q16.16 vector about an arbitrary Q16.16 axis by an angle in Q9.6 degrees
// (Rodrigues formula) and returns the unit-length result in Q1.16. Fully pipelined:
// one request is accepted every cycle while the output side takes results. Each
// request passes the 24-stage Horner sine/cosine pipeline and two normalisers, each
// of which runs a 32-stage square root followed by a one-bit-per-stage divider. A
// back-pressured output freezes the whole pipeline. A zero axis, zero vector or zero
// rotated result gives zero components with degenerate set.
module axis_angle_vector_rotate_top #(
    parameter int COMP_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aavr_in_if.sink    i_in,
    aavr_out_if.source o_out
);
    import aavr_pkg::*;

    localparam int F   = COMP_FRAC_BITS;
    localparam int UW  = F + 2;
    localparam int SWA = 3 * 32 + 16;
    localparam int SWB = 3 * 32 + 3 * 32 + 1;
    localparam int SWC = 3 * 32 + 2 * UW + 1;

    logic en;

    logic signed [31:0] in_v [3];
    logic [SWA-1:0]     in_side;

    logic               a_valid;
    logic signed [31:0] a_v [3];
    logic               a_zero;
    logic [SWA-1:0]     a_side;

    logic               b_valid;
    logic signed [UW-1:0] b_cos;
    logic signed [UW-1:0] b_sin;
    logic [SWB-1:0]     b_side;
    logic signed [31:0] b_axis [3];

    logic               c_valid;
    logic signed [UW-1:0] c_u [3];
    logic               c_zero;
    logic [SWC-1:0]     c_side;
    logic signed [31:0] c_v [3];

    logic               d_valid;
    logic signed [63:0] d_r [3];
    logic               d_flag;

    logic               e_valid;
    logic signed [17:0] e_o [3];
    logic               e_zero;
    logic               e_flag;
    logic               degen;

    assign en         = !e_valid || o_out.ready;
    assign i_in.ready = en;

    assign in_v[0] = i_in.vec_x;
    assign in_v[1] = i_in.vec_y;
    assign in_v[2] = i_in.vec_z;
    assign in_side = {i_in.axis_x, i_in.axis_y, i_in.axis_z, i_in.angle_deg};

    aavr_prescale #(.IW(32), .SW(SWA)) u_vec_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_d     (in_v),
        .i_side  (in_side),
        .o_valid (a_valid),
        .o_d     (a_v),
        .o_zero  (a_zero),
        .o_side  (a_side)
    );

    aavr_trig #(.FRAC(F), .SW(SWB)) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (a_valid),
        .i_angle (a_side[15:0]),
        .i_side  ({a_v[0], a_v[1], a_v[2], a_side[SWA-1:16], a_zero}),
        .o_valid (b_valid),
        .o_cos   (b_cos),
        .o_sin   (b_sin),
        .o_side  (b_side)
    );

    assign b_axis[0] = b_side[96:65];
    assign b_axis[1] = b_side[64:33];
    assign b_axis[2] = b_side[32:1];

    aavr_unit #(.IW(32), .FRAC(F), .SW(SWC)) u_axis_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_valid),
        .i_d     (b_axis),
        .i_side  ({b_side[SWB-1:97], b_cos, b_sin, b_side[0]}),
        .o_valid (c_valid),
        .o_u     (c_u),
        .o_zero  (c_zero),
        .o_side  (c_side)
    );

    assign c_v[0] = c_side[SWC-1:SWC-32];
    assign c_v[1] = c_side[SWC-33:SWC-64];
    assign c_v[2] = c_side[SWC-65:SWC-96];

    aavr_rod #(.FRAC(F), .SW(1)) u_rod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_u     (c_u),
        .i_v     (c_v),
        .i_cos   (c_side[2*UW:UW+1]),
        .i_sin   (c_side[UW:1]),
        .i_side  (c_side[0] | c_zero),
        .o_valid (d_valid),
        .o_r     (d_r),
        .o_side  (d_flag)
    );

    aavr_unit #(.IW(64), .FRAC(OUT_FRAC), .SW(1)) u_out_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_d     (d_r),
        .i_side  (d_flag),
        .o_valid (e_valid),
        .o_u     (e_o),
        .o_zero  (e_zero),
        .o_side  (e_flag)
    );

    assign degen            = e_flag | e_zero;
    assign o_out.valid      = e_valid;
    assign o_out.degenerate = degen;
    assign o_out.out_x      = degen ? '0 : e_o[0];
    assign o_out.out_y      = degen ? '0 : e_o[1];
    assign o_out.out_z      = degen ? '0 : e_o[2];
endmodule

// ----- rtl/aavr_check.sv -----
module aavr_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [17:0] i_out_x,
    input logic signed [17:0] i_out_y,
    input logic signed [17:0] i_out_z,
    input logic               i_degenerate
);
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("request withdrawn before acceptance");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_out_x == 0 && i_out_y == 0 && i_out_z == 0)
        else $error("degenerate result with non-zero components");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_x >= -18'sd65536 && i_out_x <= 18'sd65536
                     && i_out_y >= -18'sd65536 && i_out_y <= 18'sd65536
                     && i_out_z >= -18'sd65536 && i_out_z <= 18'sd65536)
        else $error("component beyond unit range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_z) && $stable(i_degenerate))
        else $error("stalled result changed");
endmodule

bind axis_angle_vector_rotate_top aavr_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_x      (o_out.out_x),
    .i_out_y      (o_out.out_y),
    .i_out_z      (o_out.out_z),
    .i_degenerate (o_out.degenerate)
);
